// ===== rtl/wlts_pkg.sv =====
// shared types, command codes and calendar constants of the weekly load time switch
package wlts_pkg;

   localparam int SECS_PER_MIN  = 60;
   localparam int MINS_PER_HOUR = 60;
   localparam int HOURS_PER_DAY = 24;
   localparam int DAYS_PER_WEEK = 7;

   localparam logic [1:0] CMD_TICK = 2'd0;
   localparam logic [1:0] CMD_ON   = 2'd1;
   localparam logic [1:0] CMD_OFF  = 2'd2;
   localparam logic [1:0] CMD_SET  = 2'd3;

   // packed so that day sits in bits 13..11, hour in 10..6, minute in 5..0
   typedef struct packed {
      logic [2:0] day;
      logic [4:0] hour;
      logic [5:0] minute;
   } wlts_time_type;

   typedef struct packed {
      logic          on_we;
      logic          off_we;
      logic [3:0]    channel;
      wlts_time_type entry;
   } wlts_prog_type;

   typedef struct packed {
      logic          start;
      wlts_time_type now;
   } wlts_scan_type;

endpackage

// ===== rtl/weekly_load_time_switch.sv =====
// top level of the weekly load time switch: command sequencer and result register
//
// usage
//  - req channel: one command beat (tick, program on, program off, set clock)
//    with channel, week day, hour and minute; taken when req_valid and req_ready
//  - rsp channel: one result beat per command with the load bits of loads 0..15
//    and the clock (day, hour, minute, second) as left by that command
//  - programming, clock set and a tick inside a minute finish at the accept edge;
//    their result is shown in the following cycle
//  - a tick that rolls the minute over starts the match scan: the shared compare
//    stage checks one load's on and off entries per cycle from the time tables,
//    and the result follows once every load has been checked
//  - one command is in work at a time; req_ready is low during the scan
//  - the result register frees itself in the cycle it is taken, so a new command
//    may be accepted while the previous result beat is still being handed over
//  - a stalled rsp (rsp_ready low) holds the result beat and keeps req_ready low
//  - reset: clock at day 1 00:00:00, all loads off, no entry programmed;
//    table contents are not cleared, an unprogrammed entry is never compared
module weekly_load_time_switch #(
   parameter int NUM_LOADS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [3:0]  req_channel,
   input  logic [2:0]  req_week_day,
   input  logic [4:0]  req_hour_value,
   input  logic [5:0]  req_minute_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_load_states,
   output logic [2:0]  rsp_clock_day,
   output logic [4:0]  rsp_clock_hour,
   output logic [5:0]  rsp_clock_minute,
   output logic [5:0]  rsp_clock_second
);
   import wlts_pkg::*;

   typedef enum logic {ST_IDLE, ST_SCAN} state_type;

   state_type     state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [15:0]   loads_ff, loads_in;
   wlts_time_type time_ff, time_in;
   logic [5:0]    sec_ff, sec_in;

   logic          accept;
   logic          tick;
   logic          set_en;
   wlts_time_type req_time;
   wlts_time_type now_time, next_time;
   logic [5:0]    now_second, next_second;
   logic          minute_step;
   wlts_prog_type prog;
   wlts_scan_type scan;
   logic          scan_busy;

   logic [NUM_LOADS-1:0]    load_bits;
   logic [NUM_LOADS+15:0]   load_pad;

   // only idle, and only once the result register is free or being emptied
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign tick      = accept && (req_command == CMD_TICK);
   assign set_en    = accept && (req_command == CMD_SET);
   assign req_time  = '{day: req_week_day, hour: req_hour_value, minute: req_minute_value};

   assign prog.on_we   = accept && (req_command == CMD_ON);
   assign prog.off_we  = accept && (req_command == CMD_OFF);
   assign prog.channel = req_channel;
   assign prog.entry   = req_time;

   // the scan compares against the time after the full update
   assign scan.start = minute_step;
   assign scan.now   = next_time;

   // loads above fifteen are kept but not shown
   assign load_pad = {16'd0, load_bits};

   wlts_clock u_clock (
      .clock       (clock),
      .reset       (reset),
      .tick        (tick),
      .set_en      (set_en),
      .set_time    (req_time),
      .now_time    (now_time),
      .next_time   (next_time),
      .now_second  (now_second),
      .next_second (next_second),
      .minute_step (minute_step)
   );

   wlts_scan #(
      .NUM_LOADS (NUM_LOADS)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .prog      (prog),
      .scan      (scan),
      .busy      (scan_busy),
      .load_bits (load_bits)
   );

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      loads_in     = loads_ff;
      time_in      = time_ff;
      sec_in       = sec_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (minute_step) begin
                  state_in = ST_SCAN;
               end else begin
                  // load bits cannot change outside a scan
                  rsp_valid_in = 1'b1;
                  loads_in     = load_pad[15:0];
                  time_in      = next_time;
                  sec_in       = next_second;
               end
            end
         end
         ST_SCAN: begin
            if (!scan_busy) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               loads_in     = load_pad[15:0];
               time_in      = now_time;
               sec_in       = now_second;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      state_ff     <= state_in;
      rsp_valid_ff <= rsp_valid_in;
      loads_ff     <= loads_in;
      time_ff      <= time_in;
      sec_ff       <= sec_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_load_states  = loads_ff;
   assign rsp_clock_day    = time_ff.day;
   assign rsp_clock_hour   = time_ff.hour;
   assign rsp_clock_minute = time_ff.minute;
   assign rsp_clock_second = sec_ff;

endmodule

// ===== rtl/wlts_clock.sv =====
// weekday clock counters with second tick and clock set
module wlts_clock (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   tick,
   input  logic                   set_en,
   input  wlts_pkg::wlts_time_type set_time,
   output wlts_pkg::wlts_time_type now_time,
   output wlts_pkg::wlts_time_type next_time,
   output logic [5:0]             now_second,
   output logic [5:0]             next_second,
   output logic                   minute_step
);
   import wlts_pkg::*;

   logic [5:0] sec_ff, sec_in;
   logic [5:0] min_ff, min_in;
   logic [4:0] hour_ff, hour_in;
   logic [2:0] day_ff, day_in;
   logic       set_ok;

   assign set_ok = (set_time.day >= 3'd1) && (set_time.day <= 3'(DAYS_PER_WEEK)) &&
                   (set_time.hour < 5'(HOURS_PER_DAY)) &&
                   (set_time.minute < 6'(MINS_PER_HOUR));

   always_comb begin
      sec_in      = sec_ff;
      min_in      = min_ff;
      hour_in     = hour_ff;
      day_in      = day_ff;
      minute_step = 1'b0;
      if (tick) begin
         if (sec_ff == 6'(SECS_PER_MIN - 1)) begin
            sec_in      = 6'd0;
            minute_step = 1'b1;
            if (min_ff == 6'(MINS_PER_HOUR - 1)) begin
               min_in = 6'd0;
               if (hour_ff == 5'(HOURS_PER_DAY - 1)) begin
                  hour_in = 5'd0;
                  day_in  = (day_ff < 3'(DAYS_PER_WEEK)) ? day_ff + 3'd1 : 3'd1;
               end else begin
                  hour_in = hour_ff + 5'd1;
               end
            end else begin
               min_in = min_ff + 6'd1;
            end
         end else begin
            sec_in = sec_ff + 6'd1;
         end
      end else if (set_en && set_ok) begin
         // seconds are kept on a clock set
         day_in  = set_time.day;
         hour_in = set_time.hour;
         min_in  = set_time.minute;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sec_ff  <= 6'd0;
         min_ff  <= 6'd0;
         hour_ff <= 5'd0;
         day_ff  <= 3'd1;
      end else begin
         sec_ff  <= sec_in;
         min_ff  <= min_in;
         hour_ff <= hour_in;
         day_ff  <= day_in;
      end
   end

   assign now_time    = '{day: day_ff, hour: hour_ff, minute: min_ff};
   assign next_time   = '{day: day_in, hour: hour_in, minute: min_in};
   assign now_second  = sec_ff;
   assign next_second = sec_in;

endmodule

// ===== rtl/wlts_scan.sv =====
// on/off time tables, programmed bits, load bits and the entry-per-cycle match scan
module wlts_scan #(
   parameter int NUM_LOADS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  wlts_pkg::wlts_prog_type prog,
   input  wlts_pkg::wlts_scan_type scan,
   output logic                   busy,
   output logic [NUM_LOADS-1:0]   load_bits
);
   import wlts_pkg::*;

   localparam int IDX_W = (NUM_LOADS > 1) ? $clog2(NUM_LOADS) : 1;
   localparam int CNT_W = $clog2(NUM_LOADS + 1);

   logic [13:0] on_mem  [NUM_LOADS];
   logic [13:0] off_mem [NUM_LOADS];
   logic [13:0] on_rd_ff, off_rd_ff;

   logic                 rd_act_ff, rd_act_in;
   logic [CNT_W-1:0]     rd_cnt_ff, rd_cnt_in;
   logic                 cmp_act_ff, cmp_act_in;
   logic [IDX_W-1:0]     cmp_idx_ff, cmp_idx_in;
   wlts_time_type        now_ff, now_in;
   logic [NUM_LOADS-1:0] on_prg_ff, on_prg_in;
   logic [NUM_LOADS-1:0] off_prg_ff, off_prg_in;
   logic [NUM_LOADS-1:0] bits_ff, bits_in;

   logic             ch_ok;
   logic [IDX_W-1:0] wr_idx;
   logic [IDX_W-1:0] rd_idx;

   assign ch_ok  = 32'(prog.channel) < NUM_LOADS;
   assign wr_idx = IDX_W'(prog.channel);
   assign rd_idx = rd_cnt_ff[IDX_W-1:0];

   // table writes and registered reads
   always_ff @(posedge clock) begin
      if (prog.on_we && ch_ok) begin
         on_mem[wr_idx] <= prog.entry;
      end
      if (prog.off_we && ch_ok) begin
         off_mem[wr_idx] <= prog.entry;
      end
      on_rd_ff  <= on_mem[rd_idx];
      off_rd_ff <= off_mem[rd_idx];
   end

   always_comb begin
      rd_act_in  = rd_act_ff;
      rd_cnt_in  = rd_cnt_ff;
      cmp_act_in = 1'b0;
      cmp_idx_in = cmp_idx_ff;
      now_in     = now_ff;
      on_prg_in  = on_prg_ff;
      off_prg_in = off_prg_ff;
      bits_in    = bits_ff;

      if (scan.start) begin
         rd_act_in = 1'b1;
         rd_cnt_in = '0;
         now_in    = scan.now;
      end else if (rd_act_ff) begin
         cmp_act_in = 1'b1;
         cmp_idx_in = rd_idx;
         rd_cnt_in  = rd_cnt_ff + CNT_W'(1);
         if (rd_cnt_ff == CNT_W'(NUM_LOADS - 1)) begin
            rd_act_in = 1'b0;
         end
      end

      // shared compare stage: off applied after on, so off wins
      if (cmp_act_ff) begin
         if (on_prg_ff[cmp_idx_ff] && (on_rd_ff == now_ff)) begin
            bits_in[cmp_idx_ff] = 1'b1;
         end
         if (off_prg_ff[cmp_idx_ff] && (off_rd_ff == now_ff)) begin
            bits_in[cmp_idx_ff] = 1'b0;
         end
      end

      if (prog.on_we && ch_ok) begin
         on_prg_in[wr_idx] = 1'b1;
      end
      if (prog.off_we && ch_ok) begin
         off_prg_in[wr_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_act_ff  <= 1'b0;
         rd_cnt_ff  <= '0;
         cmp_act_ff <= 1'b0;
         on_prg_ff  <= '0;
         off_prg_ff <= '0;
         bits_ff    <= '0;
      end else begin
         rd_act_ff  <= rd_act_in;
         rd_cnt_ff  <= rd_cnt_in;
         cmp_act_ff <= cmp_act_in;
         on_prg_ff  <= on_prg_in;
         off_prg_ff <= off_prg_in;
         bits_ff    <= bits_in;
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff <= cmp_idx_in;
      now_ff     <= now_in;
   end

   assign busy      = rd_act_ff | cmp_act_ff;
   assign load_bits = bits_ff;

endmodule

// ===== rtl/wlts_checker.sv =====
// port-level checks of the weekly load time switch and their bind
module wlts_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [1:0]  req_command,
   input logic [2:0]  req_week_day,
   input logic [4:0]  req_hour_value,
   input logic [5:0]  req_minute_value,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_load_states,
   input logic [2:0]  rsp_clock_day,
   input logic [4:0]  rsp_clock_hour,
   input logic [5:0]  rsp_clock_minute,
   input logic [5:0]  rsp_clock_second
);
   import wlts_pkg::*;

   logic req_beat;
   logic set_ok;

   assign req_beat = req_valid && req_ready;
   assign set_ok   = (req_week_day >= 3'd1) && (req_week_day <= 3'(DAYS_PER_WEEK)) &&
                     (req_hour_value < 5'(HOURS_PER_DAY)) &&
                     (req_minute_value < 6'(MINS_PER_HOUR));

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_load_states) &&
         $stable(rsp_clock_second) && $stable(rsp_clock_minute))
      else $error("stalled result beat changed");

   // no new command while a result waits
   a_no_take_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("command taken while result stalled");

   // commands other than tick answer in the next cycle
   a_quick_rsp: assert property (@(posedge clock) disable iff (reset)
      req_beat && (req_command != CMD_TICK) |=> rsp_valid)
      else $error("result missing after non-tick command");

   // a valid clock set shows up in the result
   a_set_clock: assert property (@(posedge clock) disable iff (reset)
      req_beat && (req_command == CMD_SET) && set_ok |=>
         (rsp_clock_day == $past(req_week_day)) && (rsp_clock_hour == $past(req_hour_value)) &&
         (rsp_clock_minute == $past(req_minute_value)))
      else $error("clock set not reflected in result");

endmodule

bind weekly_load_time_switch wlts_checker u_wlts_checker (.*);
